FILE: rtl/i2ctbe_pkg.sv
`default_nettype none
package i2ctbe_pkg;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned AddrWidth = 7;
	localparam int unsigned ByteWidth = 8;
	localparam int unsigned CntWidth = 4;
	localparam logic [CntWidth-1:0] BitsPerByte = 4'd8;
	localparam logic [CntWidth-1:0] CntMax = 4'd15;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_ADDR = 3'd1,
		PH_RECV = 3'd2,
		PH_XMIT = 3'd3,
		PH_NONE = 3'd4
	} bus_phase_t;

	typedef enum logic [1:0] {
		AK_NULL   = 2'd0,
		AK_SEND   = 2'd1,
		AK_SAMPLE = 2'd2
	} ack_phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_START    = 3'd1,
		EV_STOP     = 3'd2,
		EV_RECEIVED = 3'd3,
		EV_WRITE    = 3'd4,
		EV_READ     = 3'd5,
		EV_NEXT     = 3'd6,
		EV_NOTME    = 3'd7
	} event_t;

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_RISE  = 3'd3,
		OP_FALL  = 3'd4
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t              op;
		logic                 sda;
		logic [ByteWidth-1:0] tx;
	} cmd_t;

	typedef struct packed {
		logic                 sda_pull_low;
		event_t               code;
		logic [ByteWidth-1:0] data;
	} result_t;

endpackage
`default_nettype wire

FILE: rtl/i2ctbe_queue.sv
`default_nettype none
module i2ctbe_queue #(
	parameter int unsigned DEPTH = i2ctbe_pkg::QueueDepth,
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/i2ctbe_front.sv
`default_nettype none
module i2ctbe_front #(
	parameter int unsigned DEPTH = i2ctbe_pkg::QueueDepth
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              req_type,
	input  wire logic                              edge_rising,
	input  wire logic                              sda_level,
	input  wire logic                              scl_level,
	input  wire logic [i2ctbe_pkg::ByteWidth-1:0]  tx_byte,
	input  wire logic                              cmd_take,
	output i2ctbe_pkg::cmd_t                       cmd,
	output logic                                   cmd_empty
);

	i2ctbe_pkg::cmd_t cls;

	// req_type low: START or STOP on an SDA change while SCL is high, else no-op; req_type high: SCL rise or fall
	always_comb begin
		cls.sda = sda_level;
		cls.tx  = tx_byte;
		if (!req_type) begin
			if (scl_level) begin
				cls.op = edge_rising ? i2ctbe_pkg::OP_STOP : i2ctbe_pkg::OP_START;
			end else begin
				cls.op = i2ctbe_pkg::OP_NOP;
			end
		end else begin
			cls.op = edge_rising ? i2ctbe_pkg::OP_RISE : i2ctbe_pkg::OP_FALL;
		end
	end

	i2ctbe_queue #(
		.DEPTH (DEPTH),
		.WIDTH ($bits(i2ctbe_pkg::cmd_t))
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls),
		.full    (full),
		.rd_en   (cmd_take),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

endmodule
`default_nettype wire

FILE: rtl/i2ctbe_back.sv
`default_nettype none
module i2ctbe_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [i2ctbe_pkg::AddrWidth-1:0]   cfg_addr,
	input  wire i2ctbe_pkg::cmd_t                   cmd,
	input  wire logic                               cmd_empty,
	output logic                                    cmd_take,
	input  wire logic                               res_full,
	output i2ctbe_pkg::result_t                     res
);

	localparam int unsigned BW = i2ctbe_pkg::ByteWidth;
	localparam int unsigned CW = i2ctbe_pkg::CntWidth;

	logic [i2ctbe_pkg::AddrWidth-1:0] own_addr_q;
	i2ctbe_pkg::bus_phase_t           phase_q, phase_d;
	i2ctbe_pkg::ack_phase_t           ack_q, ack_d;
	logic [BW-1:0]                    shift_q, shift_d;
	logic [CW-1:0]                    cnt_q, cnt_d;
	logic                             drive_q, drive_d;

	logic [BW-1:0] sh_in;
	logic [CW-1:0] cnt_inc;
	logic          byte_done;
	logic          hit_wr;
	logic          hit_rd;
	logic          tx_bit;

	assign cmd_take  = !cmd_empty && !res_full;
	assign sh_in     = {shift_q[BW-2:0], cmd.sda};
	assign cnt_inc   = (cnt_q < i2ctbe_pkg::CntMax) ? cnt_q + 1'b1 : cnt_q;
	assign byte_done = (cnt_inc == i2ctbe_pkg::BitsPerByte);
	assign hit_wr    = (sh_in == {own_addr_q, 1'b0});
	assign hit_rd    = (sh_in == {own_addr_q, 1'b1});
	assign tx_bit    = shift_q[3'd7 - cnt_q[2:0]];

	// next state
	always_comb begin
		phase_d = phase_q;
		ack_d   = ack_q;
		shift_d = shift_q;
		cnt_d   = cnt_q;
		drive_d = drive_q;
		case (cmd.op)
			i2ctbe_pkg::OP_START: begin
				shift_d = '0;
				cnt_d   = '0;
				phase_d = i2ctbe_pkg::PH_ADDR;
			end
			i2ctbe_pkg::OP_STOP: begin
				shift_d = '0;
				cnt_d   = '0;
				phase_d = i2ctbe_pkg::PH_IDLE;
			end
			i2ctbe_pkg::OP_RISE: begin
				case (phase_q)
					i2ctbe_pkg::PH_ADDR: begin
						shift_d = sh_in;
						cnt_d   = cnt_inc;
						if (byte_done) begin
							cnt_d = '0;
							if (hit_wr) begin
								phase_d = i2ctbe_pkg::PH_RECV;
								ack_d   = i2ctbe_pkg::AK_SEND;
								shift_d = '0;
							end else if (hit_rd) begin
								phase_d = i2ctbe_pkg::PH_XMIT;
								ack_d   = i2ctbe_pkg::AK_SEND;
								shift_d = cmd.tx;
							end else begin
								phase_d = i2ctbe_pkg::PH_NONE;
								ack_d   = i2ctbe_pkg::AK_NULL;
								shift_d = '0;
							end
						end
					end
					i2ctbe_pkg::PH_XMIT: begin
						if (ack_q == i2ctbe_pkg::AK_SAMPLE) begin
							ack_d = i2ctbe_pkg::AK_NULL;
							if (cmd.sda) begin
								phase_d = i2ctbe_pkg::PH_NONE;
							end
						end else if (cnt_q == i2ctbe_pkg::BitsPerByte) begin
							cnt_d   = '0;
							ack_d   = i2ctbe_pkg::AK_SAMPLE;
							shift_d = cmd.tx;
						end
					end
					i2ctbe_pkg::PH_RECV: begin
						if (ack_q == i2ctbe_pkg::AK_SEND) begin
							ack_d = i2ctbe_pkg::AK_NULL;
						end else if (ack_q == i2ctbe_pkg::AK_NULL) begin
							shift_d = sh_in;
							cnt_d   = cnt_inc;
							if (byte_done) begin
								shift_d = '0;
								cnt_d   = '0;
								ack_d   = i2ctbe_pkg::AK_SEND;
							end
						end
					end
					default: begin
					end
				endcase
			end
			i2ctbe_pkg::OP_FALL: begin
				case (phase_q)
					i2ctbe_pkg::PH_XMIT: begin
						if (ack_q == i2ctbe_pkg::AK_SEND) begin
							drive_d = 1'b1;
							ack_d   = i2ctbe_pkg::AK_NULL;
						end else if (ack_q == i2ctbe_pkg::AK_SAMPLE) begin
							drive_d = 1'b0;
						end else if (ack_q == i2ctbe_pkg::AK_NULL) begin
							// past the last bit the line is released
							if (cnt_q >= i2ctbe_pkg::BitsPerByte) begin
								drive_d = 1'b0;
							end else begin
								drive_d = !tx_bit;
								cnt_d   = cnt_q + 1'b1;
							end
						end
					end
					i2ctbe_pkg::PH_RECV: begin
						if (ack_q == i2ctbe_pkg::AK_SEND) begin
							drive_d = 1'b1;
						end else if (ack_q == i2ctbe_pkg::AK_NULL) begin
							drive_d = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// result
	always_comb begin
		res.sda_pull_low = drive_d;
		res.code         = i2ctbe_pkg::EV_NONE;
		res.data         = '0;
		case (cmd.op)
			i2ctbe_pkg::OP_START: res.code = i2ctbe_pkg::EV_START;
			i2ctbe_pkg::OP_STOP:  res.code = i2ctbe_pkg::EV_STOP;
			i2ctbe_pkg::OP_RISE: begin
				if (phase_q == i2ctbe_pkg::PH_ADDR && byte_done) begin
					if (hit_wr) begin
						res.code = i2ctbe_pkg::EV_WRITE;
					end else if (hit_rd) begin
						res.code = i2ctbe_pkg::EV_READ;
					end else begin
						res.code = i2ctbe_pkg::EV_NOTME;
					end
				end else if (phase_q == i2ctbe_pkg::PH_XMIT
						&& ack_q != i2ctbe_pkg::AK_SAMPLE
						&& cnt_q == i2ctbe_pkg::BitsPerByte) begin
					res.code = i2ctbe_pkg::EV_NEXT;
				end else if (phase_q == i2ctbe_pkg::PH_RECV
						&& ack_q == i2ctbe_pkg::AK_NULL && byte_done) begin
					res.code = i2ctbe_pkg::EV_RECEIVED;
					res.data = sh_in;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= '0;
			phase_q    <= i2ctbe_pkg::PH_IDLE;
			ack_q      <= i2ctbe_pkg::AK_NULL;
			shift_q    <= '0;
			cnt_q      <= '0;
			drive_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				own_addr_q <= cfg_addr;
			end
			if (cmd_take) begin
				phase_q <= phase_d;
				ack_q   <= ack_d;
				shift_q <= shift_d;
				cnt_q   <= cnt_d;
				drive_q <= drive_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/i2c_target_bit_engine.sv
`default_nettype none
// An event waits in the event queue; the back end then writes its result into the result
// queue, whose head drives the result ports. One event per clock while the result queue has room.
// Event and result queues of QUEUE_DEPTH entries each absorb stalls on either side.
// Reset (arst_n low, asynchronous): queues empty, bus idle, no ACK pending,
// shift register and bit counter zero, SDA drive state clear, own address zero.
module i2c_target_bit_engine #(
	parameter int unsigned QUEUE_DEPTH = i2ctbe_pkg::QueueDepth
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              req_type,
	input  wire logic                              edge_rising,
	input  wire logic                              sda_level,
	input  wire logic                              scl_level,
	input  wire logic [i2ctbe_pkg::ByteWidth-1:0]  tx_byte,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic                                   sda_pull_low,
	output logic [2:0]                             event_code,
	output logic [i2ctbe_pkg::ByteWidth-1:0]       event_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [i2ctbe_pkg::AddrWidth-1:0]  cfg_data
);

	i2ctbe_pkg::cmd_t    cmd;
	logic                cmd_empty;
	logic                cmd_take;
	i2ctbe_pkg::result_t res_in;
	i2ctbe_pkg::result_t res_out;
	logic                res_full;

	assign cfg_ready = 1'b1;

	i2ctbe_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.req_type    (req_type),
		.edge_rising (edge_rising),
		.sda_level   (sda_level),
		.scl_level   (scl_level),
		.tx_byte     (tx_byte),
		.cmd_take    (cmd_take),
		.cmd         (cmd),
		.cmd_empty   (cmd_empty)
	);

	i2ctbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_addr  (cfg_data),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_take  (cmd_take),
		.res_full  (res_full),
		.res       (res_in)
	);

	i2ctbe_queue #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(i2ctbe_pkg::result_t))
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_take),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign sda_pull_low = res_out.sda_pull_low;
	assign event_code   = res_out.code;
	assign event_data   = res_out.data;

endmodule
`default_nettype wire

FILE: tb/tb_i2c_target_bit_engine.sv
`timescale 1ns / 1ps

module tb_i2c_target_bit_engine;

	localparam int unsigned ByteWidth = i2ctbe_pkg::ByteWidth;
	localparam int unsigned AddrWidth = i2ctbe_pkg::AddrWidth;
	localparam int unsigned CntWidth = i2ctbe_pkg::CntWidth;
	localparam logic [CntWidth-1:0] CntMax = i2ctbe_pkg::CntMax;
	localparam logic [CntWidth-1:0] BitsPerByte = i2ctbe_pkg::BitsPerByte;

	typedef struct packed {
		logic                 req_type;
		logic                 edge_rising;
		logic                 sda_level;
		logic                 scl_level;
		logic [ByteWidth-1:0] tx_byte;
	} pin_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 req_type = 1'b0;
	logic                 edge_rising = 1'b0;
	logic                 sda_level = 1'b0;
	logic                 scl_level = 1'b0;
	logic [ByteWidth-1:0] tx_byte = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 sda_pull_low;
	logic [2:0]           event_code;
	logic [ByteWidth-1:0] event_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [AddrWidth-1:0] cfg_data = '0;

	// target model state
	logic [AddrWidth-1:0]   target_addr = '0;
	i2ctbe_pkg::bus_phase_t line_phase = i2ctbe_pkg::PH_IDLE;
	i2ctbe_pkg::ack_phase_t ack_mode = i2ctbe_pkg::AK_NULL;
	logic [ByteWidth-1:0]   shreg = '0;
	logic [CntWidth-1:0]    bitcnt = '0;
	logic                   drive_low = 1'b0;

	pin_event_t          pending_events[$];
	i2ctbe_pkg::result_t due_results[$];
	pin_event_t          cur_event;
	i2ctbe_pkg::result_t oldest_due;
	int                  queued_count = 0;
	int                  mismatch_count = 0;
	int                  send_idle_pct = 13;
	int                  recv_idle_pct = 45;

	i2c_target_bit_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.edge_rising  (edge_rising),
		.sda_level    (sda_level),
		.scl_level    (scl_level),
		.tx_byte      (tx_byte),
		.empty        (empty),
		.pop          (pop),
		.sda_pull_low (sda_pull_low),
		.event_code   (event_code),
		.event_data   (event_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void shift_in_bit(input logic b);
		shreg = {shreg[ByteWidth-2:0], b};
		if (bitcnt < CntMax)
			bitcnt = bitcnt + 1'b1;
	endfunction

	function automatic i2ctbe_pkg::result_t next_result(input pin_event_t e);
		i2ctbe_pkg::result_t  r;
		i2ctbe_pkg::event_t   code;
		logic [ByteWidth-1:0] data;
		logic [ByteWidth-1:0] wr_frame;
		code = i2ctbe_pkg::EV_NONE;
		data = '0;
		wr_frame = {target_addr, 1'b0};
		if (!e.req_type) begin
			// start or stop only while SCL is high
			if (e.scl_level) begin
				shreg = '0;
				bitcnt = '0;
				if (!e.edge_rising) begin
					line_phase = i2ctbe_pkg::PH_ADDR;
					code = i2ctbe_pkg::EV_START;
				end else begin
					line_phase = i2ctbe_pkg::PH_IDLE;
					code = i2ctbe_pkg::EV_STOP;
				end
			end
		end else if (e.edge_rising) begin
			case (line_phase)
				i2ctbe_pkg::PH_ADDR: begin
					shift_in_bit(e.sda_level);
					if (bitcnt == BitsPerByte) begin
						bitcnt = '0;
						if (shreg == wr_frame) begin
							line_phase = i2ctbe_pkg::PH_RECV;
							ack_mode = i2ctbe_pkg::AK_SEND;
							shreg = '0;
							code = i2ctbe_pkg::EV_WRITE;
						end else if (shreg == (wr_frame | 8'd1)) begin
							line_phase = i2ctbe_pkg::PH_XMIT;
							ack_mode = i2ctbe_pkg::AK_SEND;
							shreg = e.tx_byte;
							code = i2ctbe_pkg::EV_READ;
						end else begin
							line_phase = i2ctbe_pkg::PH_NONE;
							ack_mode = i2ctbe_pkg::AK_NULL;
							shreg = '0;
							code = i2ctbe_pkg::EV_NOTME;
						end
					end
				end
				i2ctbe_pkg::PH_XMIT: begin
					if (ack_mode == i2ctbe_pkg::AK_SAMPLE) begin
						ack_mode = i2ctbe_pkg::AK_NULL;
						if (e.sda_level)
							line_phase = i2ctbe_pkg::PH_NONE;
					end else if (bitcnt == BitsPerByte) begin
						bitcnt = '0;
						ack_mode = i2ctbe_pkg::AK_SAMPLE;
						shreg = e.tx_byte;
						code = i2ctbe_pkg::EV_NEXT;
					end
				end
				i2ctbe_pkg::PH_RECV: begin
					if (ack_mode == i2ctbe_pkg::AK_SEND) begin
						ack_mode = i2ctbe_pkg::AK_NULL;
					end else if (ack_mode == i2ctbe_pkg::AK_NULL) begin
						shift_in_bit(e.sda_level);
						if (bitcnt == BitsPerByte) begin
							data = shreg;
							code = i2ctbe_pkg::EV_RECEIVED;
							shreg = '0;
							bitcnt = '0;
							ack_mode = i2ctbe_pkg::AK_SEND;
						end
					end
				end
				default: ;
			endcase
		end else begin
			case (line_phase)
				i2ctbe_pkg::PH_XMIT: begin
					if (ack_mode == i2ctbe_pkg::AK_SEND) begin
						drive_low = 1'b1;
						ack_mode = i2ctbe_pkg::AK_NULL;
					end else if (ack_mode == i2ctbe_pkg::AK_SAMPLE) begin
						drive_low = 1'b0;
					end else if (ack_mode == i2ctbe_pkg::AK_NULL) begin
						// past the last bit the line is released
						if (bitcnt >= BitsPerByte) begin
							drive_low = 1'b0;
						end else begin
							drive_low = ~shreg[3'd7 - bitcnt[2:0]];
							bitcnt = bitcnt + 1'b1;
						end
					end
				end
				i2ctbe_pkg::PH_RECV: begin
					if (ack_mode == i2ctbe_pkg::AK_SEND)
						drive_low = 1'b1;
					else if (ack_mode == i2ctbe_pkg::AK_NULL)
						drive_low = 1'b0;
				end
				default: ;
			endcase
		end
		r.sda_pull_low = drive_low;
		r.code = code;
		r.data = data;
		return r;
	endfunction

	task automatic queue_event(input logic req, input logic rise, input logic sda,
			input logic scl, input logic [ByteWidth-1:0] tx);
		pin_event_t e;
		e.req_type = req;
		e.edge_rising = rise;
		e.sda_level = sda;
		e.scl_level = scl;
		e.tx_byte = tx;
		pending_events.push_back(e);
		queued_count++;
	endtask

	task automatic queue_pulse(input logic sda);
		queue_event(1'b1, 1'b1, sda, 1'b1, 8'($urandom));
		queue_event(1'b1, 1'b0, 1'($urandom), 1'b0, 8'($urandom));
	endtask

	task automatic queue_start();
		queue_event(1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom));
	endtask

	task automatic queue_stop();
		queue_event(1'b0, 1'b1, 1'b1, 1'b1, 8'($urandom));
	endtask

	// eight data clocks plus the ACK clock; extra_fall adds a stray SCL fall near the end
	task automatic queue_byte(input logic [ByteWidth-1:0] bits, input logic ack,
			input logic extra_fall);
		for (int i = ByteWidth - 1; i >= 0; i--) begin
			queue_pulse(bits[i]);
			if (extra_fall && i == 1)
				queue_event(1'b1, 1'b0, 1'($urandom), 1'b0, 8'($urandom));
		end
		queue_pulse(ack);
	endtask

	task automatic queue_transfer();
		logic [ByteWidth-1:0] frame;
		int                   pick;
		int                   nbytes;
		logic                 nack;
		pick = $urandom_range(9);
		if (pick < 4)
			frame = {target_addr, 1'b0};
		else if (pick < 8)
			frame = {target_addr, 1'b1};
		else
			frame = 8'($urandom);
		queue_start();
		queue_byte(frame, 1'($urandom), 1'b0);
		nbytes = $urandom_range(4);
		for (int k = 0; k < nbytes; k++) begin
			// controller ACKs reads, may NACK the last one
			nack = (k == nbytes - 1) ? 1'($urandom) : 1'b0;
			queue_byte(8'($urandom), frame[0] ? nack : 1'($urandom),
				$urandom_range(9) == 0);
		end
		if ($urandom_range(9) < 7)
			queue_stop();
	endtask

	task automatic queue_noise();
		case ($urandom_range(3))
			0: repeat ($urandom_range(1, 4))
				queue_event(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
					8'($urandom));
			1: begin
				// broken frame, cut short
				queue_start();
				repeat ($urandom_range(12))
					queue_pulse(1'($urandom));
			end
			2: repeat ($urandom_range(1, 3))
				queue_event(1'b1, 1'b0, 1'($urandom), 1'b0, 8'($urandom));
			default: queue_event(1'b0, 1'($urandom), 1'($urandom), 1'b0, 8'($urandom));
		endcase
	endtask

	task automatic queue_random(input int n);
		int first;
		first = queued_count;
		while (queued_count - first < n) begin
			if ($urandom_range(99) < 75)
				queue_transfer();
			else
				queue_noise();
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || push || due_results.size() != 0);
	endtask

	task automatic set_target_address(input logic [AddrWidth-1:0] a);
		wait_drained();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= a;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		target_addr = a;
	endtask

	// driver: holds an item until the block takes it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				due_results.push_back(next_result(cur_event));
			if (push && full) begin
				// keep presenting the same item
			end else if (pending_events.size() != 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				cur_event = pending_events.pop_front();
				push <= 1'b1;
				req_type <= cur_event.req_type;
				edge_rising <= cur_event.edge_rising;
				sda_level <= cur_event.sda_level;
				scl_level <= cur_event.scl_level;
				tx_byte <= cur_event.tx_byte;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					$display("%0t result with nothing expected: code %0d data %0h",
						$time, event_code, event_data);
					mismatch_count++;
				end else begin
					oldest_due = due_results.pop_front();
					if (sda_pull_low !== oldest_due.sda_pull_low) begin
						$display("%0t sda_pull_low: expected %0b actual %0b", $time,
							oldest_due.sda_pull_low, sda_pull_low);
						mismatch_count++;
					end
					if (event_code !== oldest_due.code) begin
						$display("%0t event_code: expected %0d actual %0d", $time,
							oldest_due.code, event_code);
						mismatch_count++;
					end
					if (event_data !== oldest_due.data) begin
						$display("%0t event_data: expected %0h actual %0h", $time,
							oldest_due.data, event_data);
						mismatch_count++;
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset address is zero: read frame is 8'h01
		queue_event(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
		queue_event(1'b0, 1'b1, 1'b1, 1'b0, 8'hFF);
		queue_event(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
		queue_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
		queue_stop();
		queue_start();
		queue_byte(8'h01, 1'b0, 1'b0);
		queue_stop();

		set_target_address(7'h7F);
		queue_random(300);
		set_target_address(7'h00);
		queue_random(150);

		wait_drained();
		send_idle_pct = 45;
		recv_idle_pct = 13;
		queue_random(150);
		set_target_address(7'($urandom_range(1, 126)));
		queue_random(300);

		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_target_address(7'($urandom));
		queue_random(300);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && due_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
rtl/i2ctbe_pkg.sv
rtl/i2ctbe_queue.sv
rtl/i2ctbe_front.sv
rtl/i2ctbe_back.sv
rtl/i2c_target_bit_engine.sv
tb/tb_i2c_target_bit_engine.sv
